// ===== src/upqs_pkg.sv =====
package upqs_pkg;

  // default sizing
  localparam int DEF_NUM_PORTS      = 4;
  localparam int DEF_URGENCY_LEVELS = 4;
  localparam int DEF_NUM_QUEUES     = 16;
  localparam int DEF_FIFO_DEPTH     = 16;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int PORT_FW  = 2;
  localparam int QID_W    = 4;
  localparam int COUNT_W  = 8;
  localparam int MAP_W    = 32;

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_URGENCY_MAP = '0;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ARRIVAL = 2'd0,
    ACT_DEPART  = 2'd1,
    ACT_DROP    = 2'd2,
    ACT_NEXT    = 2'd3
  } action_e;

endpackage

// ===== src/urgency_priority_queue_selector_unit.sv =====
// Strict-priority scheduler over per-port FIFOs of queue identifiers. Each request
// (start high while busy is low) names an action, a port and a queue: an arrival
// counts a message and appends the queue to the FIFO of its configured urgency, a
// departure lowers the count, a drop lowers the count and takes back the newest entry
// of the FIFO last appended to, and a next-urgent request pops the head of the
// highest non-empty urgency FIFO of the port. Every request gives exactly one result,
// shown on the result ports for one cycle under done_o, in the cycle after acceptance;
// the receiver cannot stall, so whatever logic takes the results must sample them in
// that cycle. busy stays low: one request can be accepted on every clock, the figure
// being set by the update of the head/fill registers in the accepting cycle and the
// registered read of the entry store that holds the FIFO contents. The entry store
// needs no clearing after reset, since only entries inside a FIFO's fill are read.
// The urgency map is written over the APB port at byte address 0 and should only be
// changed while no requests are in flight.
module urgency_priority_queue_selector_unit
  import upqs_pkg::*;
#(
  parameter int NUM_PORTS      = DEF_NUM_PORTS,
  parameter int URGENCY_LEVELS = DEF_URGENCY_LEVELS,
  parameter int NUM_QUEUES     = DEF_NUM_QUEUES,
  parameter int FIFO_DEPTH     = DEF_FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // request side
  input  logic                  start,
  output logic                  busy,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [PORT_FW-1:0]    port_i,
  input  logic [QID_W-1:0]      queue_id_i,
  input  logic                  queue_is_input_i,
  // result side
  output logic                  done_o,
  output logic                  next_valid_o,
  output logic [QID_W-1:0]      next_queue_o,
  output logic [COUNT_W-1:0]    port_count_o,
  output logic                  overflow_o
);

  localparam int NFIFOS      = NUM_PORTS * URGENCY_LEVELS;
  localparam int STORE_DEPTH = NFIFOS * FIFO_DEPTH;
  localparam int PORT_W      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int URG_W       = $clog2(URGENCY_LEVELS);
  localparam int SLOT_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef logic [FILL_W-1:0] fill_row_t [URGENCY_LEVELS];
  typedef logic [SLOT_W-1:0] head_row_t [URGENCY_LEVELS];

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  logic [MAP_W-1:0] map_q;
  logic             reg_sel;

  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_URGENCY_MAP);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? map_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      map_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // per-port state: fifo heads and fills by urgency, count, last urgency
  // ---------------------------------------------------------------------------
  fill_row_t         fill_q  [NUM_PORTS];
  head_row_t         head_q  [NUM_PORTS];
  logic [COUNT_W-1:0] count_q [NUM_PORTS];
  logic [URG_W-1:0]   last_q  [NUM_PORTS];

  // entry store, one row of FIFO_DEPTH slots per (port, urgency) fifo
  logic [QID_W-1:0]  store_mem [STORE_DEPTH];

  logic              accept;
  logic              port_ok;
  logic              queue_ok;
  logic [PORT_W-1:0] pidx;
  action_e           act;

  // current row of the addressed port and its next value
  fill_row_t          row_fill, row_fill_d;
  head_row_t          row_head, row_head_d;
  logic [COUNT_W-1:0] cnt_cur, cnt_d;
  logic [URG_W-1:0]   last_cur, last_d;

  logic               any_ne;
  logic [URG_W-1:0]   top_lvl;
  logic [MAP_W-1:0]   map_shift;
  logic [1:0]         urg_raw;
  logic [URG_W-1:0]   arr_lvl;
  logic [FILL_W:0]    tail_sum;
  logic [SLOT_W-1:0]  tail_slot;
  logic [SLOT_W-1:0]  pop_slot;

  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic               nvalid, ovf;

  assign busy     = 1'b0;  // never busy: every request is taken in the cycle it is offered
  assign accept   = start && !busy;
  assign act      = action_e'(action_i);
  assign pidx     = PORT_W'(port_i);
  assign port_ok  = (32'(port_i) < NUM_PORTS);
  assign queue_ok = !queue_is_input_i && (32'(queue_id_i) < NUM_QUEUES);

  // urgency of the named queue, clamped to the top level
  assign map_shift = map_q >> {queue_id_i, 1'b0};
  assign urg_raw   = map_shift[1:0];
  assign arr_lvl   = (32'(urg_raw) >= URGENCY_LEVELS) ? URG_W'(URGENCY_LEVELS - 1)
                                                      : URG_W'(urg_raw);

  function automatic logic [ADDR_W-1:0] store_addr(input logic [PORT_W-1:0] p,
                                                   input logic [URG_W-1:0]  l,
                                                   input logic [SLOT_W-1:0] s);
    logic [ADDR_W-1:0] f;
    f = ADDR_W'(p) * ADDR_W'(URGENCY_LEVELS) + ADDR_W'(l);
    return f * ADDR_W'(FIFO_DEPTH) + ADDR_W'(s);
  endfunction

  always_comb begin
    row_fill = fill_q[pidx];
    row_head = head_q[pidx];
    cnt_cur  = count_q[pidx];
    last_cur = last_q[pidx];

    row_fill_d = row_fill;
    row_head_d = row_head;
    cnt_d      = cnt_cur;
    last_d     = last_cur;

    // highest non-empty urgency of the port
    any_ne  = 1'b0;
    top_lvl = '0;
    for (int l = 0; l < URGENCY_LEVELS; l++) begin
      if (row_fill[l] != '0) begin
        any_ne  = 1'b1;
        top_lvl = URG_W'(l);
      end
    end

    // tail slot of the arrival fifo, only used while it is not full
    tail_sum = (FILL_W + 1)'(row_head[arr_lvl]) + (FILL_W + 1)'(row_fill[arr_lvl]);
    if (tail_sum >= (FILL_W + 1)'(FIFO_DEPTH)) begin
      tail_sum = tail_sum - (FILL_W + 1)'(FIFO_DEPTH);
    end
    tail_slot = SLOT_W'(tail_sum);
    pop_slot  = row_head[top_lvl];

    mem_we = 1'b0;
    mem_re = 1'b0;
    nvalid = 1'b0;
    ovf    = 1'b0;

    unique case (act)
      ACT_NEXT: begin
        if (any_ne) begin
          nvalid = 1'b1;
          mem_re = 1'b1;
          row_head_d[top_lvl] = (pop_slot == SLOT_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : pop_slot + 1'b1;
          row_fill_d[top_lvl] = row_fill[top_lvl] - 1'b1;
        end
      end
      ACT_ARRIVAL: begin
        if (queue_ok) begin
          if (cnt_cur != COUNT_MAX) cnt_d = cnt_cur + 1'b1;
          if (row_fill[arr_lvl] >= FILL_W'(FIFO_DEPTH)) begin
            ovf = 1'b1;
          end else begin
            mem_we = 1'b1;
            row_fill_d[arr_lvl] = row_fill[arr_lvl] + 1'b1;
          end
          last_d = arr_lvl;
        end
      end
      ACT_DEPART: begin
        if (queue_ok && cnt_cur != '0) cnt_d = cnt_cur - 1'b1;
      end
      ACT_DROP: begin
        if (queue_ok) begin
          if (cnt_cur != '0) cnt_d = cnt_cur - 1'b1;
          // take back the newest entry of the last appended fifo
          if (row_fill[last_cur] != '0) row_fill_d[last_cur] = row_fill[last_cur] - 1'b1;
        end
      end
      default: ;
    endcase

    mem_waddr = store_addr(pidx, arr_lvl, tail_slot);
    mem_raddr = store_addr(pidx, top_lvl, pop_slot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        count_q[p] <= '0;
        last_q[p]  <= '0;
        for (int l = 0; l < URGENCY_LEVELS; l++) begin
          fill_q[p][l] <= '0;
          head_q[p][l] <= '0;
        end
      end
    end else if (accept && port_ok) begin
      fill_q[pidx]  <= row_fill_d;
      head_q[pidx]  <= row_head_d;
      count_q[pidx] <= cnt_d;
      last_q[pidx]  <= last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // entry store: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [QID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (accept && port_ok && mem_we) begin
      store_mem[mem_waddr] <= queue_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && port_ok && mem_re) begin
      rdata_q <= store_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // result stage, in the cycle after acceptance
  // ---------------------------------------------------------------------------
  logic               done_q;
  logic               nvalid_q;
  logic               ovf_q;
  logic [COUNT_W-1:0] res_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  // out-of-range port reports all zero
  always_ff @(posedge clk_i) begin
    if (accept) begin
      nvalid_q    <= port_ok && nvalid;
      ovf_q       <= port_ok && ovf;
      res_count_q <= port_ok ? cnt_d : '0;
    end
  end

  assign done_o       = done_q;
  assign next_valid_o = done_q && nvalid_q;
  assign next_queue_o = (done_q && nvalid_q) ? rdata_q : '0;
  assign port_count_o = done_q ? res_count_q : '0;
  assign overflow_o   = done_q && ovf_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_done_follows_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result strobe without a request in the previous cycle");

  a_pop_and_overflow_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(next_valid_o && overflow_o))
    else $error("pop and overflow flagged in the same result");

  a_pop_when_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && port_ok && act == ACT_NEXT && any_ne) |=> (done_o && next_valid_o))
    else $error("next-urgent on a non-empty port returned no queue");

endmodule
